/* src/assert_macros.svh */
// Assertion helpers for the rate limiter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("assert failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assert failed");
`else
`define ASSERT_IMPL(label, cond)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/kwrl_pkg.sv */
package kwrl_pkg;
  localparam int TableEntries = 64;
  localparam int KeyBits = 32;
  localparam int TimeBits = 48;
  localparam int NumTables = 2;
  localparam int SlotBits = $clog2(TableEntries);
  localparam int FillBits = $clog2(TableEntries + 1);
  localparam int CntBits = 32;
  localparam int WinBits = 32;
  localparam logic [WinBits-1:0] WindowReset = WinBits'(60000);
  localparam logic [CntBits-1:0] CntMax = '1;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic                tsel;
    logic [KeyBits-1:0]  key;
    logic [TimeBits-1:0] now;
    logic                rdy;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_UPDATE,
    BK_OUT
  } bk_state_t;
endpackage

/* src/kwrl_front.sv */
module kwrl_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_table_select,
  input  logic [31:0]            in_key_id,
  input  logic [47:0]            in_now_ms,
  input  logic                   in_audit_ready,
  output logic                   q_valid,
  input  logic                   q_pop,
  output kwrl_pkg::item_t        q_item
);
  import kwrl_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  item_t                 mem_r [QueueDepth];
  logic [PtrBits-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PtrBits:0]      cnt_r;
  item_t                 item_in;
  logic                  push;

  // Trim the item to the kept widths
  always_comb begin
    item_in.tsel = in_table_select;
    item_in.key  = KeyBits'(in_key_id);
    item_in.now  = TimeBits'(in_now_ms);
    item_in.rdy  = in_audit_ready;
  end

  assign in_ready = (cnt_r != (PtrBits+1)'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // Store beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

/* src/kwrl_back.sv */
module kwrl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [kwrl_pkg::WinBits-1:0]  window,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  kwrl_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_emitted,
  output logic [31:0]                   out_window_count,
  output logic                          busy
);
  import kwrl_pkg::*;

  localparam int Slots = NumTables * TableEntries;
  localparam int GBits = $clog2(Slots);

  // Keys and ranks are cells searched in parallel; times and counts are memories
  logic [KeyBits-1:0]  key_r   [Slots];
  logic [TimeBits-1:0] last_r  [Slots];
  logic [CntBits-1:0]  sup_r   [Slots];
  logic [SlotBits-1:0] rank_r  [Slots];
  logic [Slots-1:0]    hasem_r;
  logic [FillBits-1:0] fill_r  [NumTables];

  bk_state_t           state_r, state_nxt;
  item_t               it_r;
  logic                hit_r;
  logic [SlotBits-1:0] slot_r;
  logic                res_em_r;
  logic [CntBits-1:0]  res_cnt_r;
  logic [TimeBits-1:0] last_rd_r;
  logic [CntBits-1:0]  sup_rd_r;

  logic [TableEntries-1:0] match_v, lru_v;
  logic                    hit_c;
  logic [SlotBits-1:0]     hit_idx, lru_idx, slot_c;
  logic [FillBits-1:0]     fill_c;
  logic [GBits-1:0]        gs;
  logic [SlotBits-1:0]     old_rank;
  logic [TimeBits-1:0]     elapsed;
  logic                    open;
  logic                    full;

  assign fill_c = fill_r[it_r.tsel];
  assign full   = (fill_c == FillBits'(TableEntries));

  // Match keys and find least recent slot in the selected table
  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = 0; i < TableEntries; i++) begin
      match_v[i] = (FillBits'(i) < fill_c) &&
                   (key_r[{it_r.tsel, SlotBits'(i)}] == it_r.key);
      lru_v[i]   = (rank_r[{it_r.tsel, SlotBits'(i)}] == '0);
    end
    for (int i = 0; i < TableEntries; i++) begin
      if (match_v[i]) hit_idx = SlotBits'(i);
      if (lru_v[i])   lru_idx = SlotBits'(i);
    end
    hit_c = |match_v;
    if (hit_c)      slot_c = hit_idx;
    else if (full)  slot_c = lru_idx;
    else            slot_c = SlotBits'(fill_c);
  end

  // Read entry payload for the chosen slot
  always_ff @(posedge clk) begin
    if (state_r == BK_MATCH) begin
      last_rd_r <= last_r[{it_r.tsel, slot_c}];
      sup_rd_r  <= sup_r[{it_r.tsel, slot_c}];
    end
  end

  assign gs       = {it_r.tsel, slot_r};
  assign old_rank = rank_r[gs];
  assign elapsed  = it_r.now - last_rd_r;
  assign open     = !hit_r || !hasem_r[gs] || (elapsed >= TimeBits'(window));

  // Sequence one item: match, update, deliver
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_MATCH;
        end
      end
      BK_MATCH:  state_nxt = it_r.rdy ? BK_UPDATE : BK_OUT;
      BK_UPDATE: state_nxt = BK_OUT;
      BK_OUT:    if (out_ready) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  assign out_valid        = (state_r == BK_OUT);
  assign out_emitted      = res_em_r;
  assign out_window_count = res_cnt_r;
  assign busy             = (state_r != BK_IDLE);

  // Hold item and lookup result
  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_item;
    if (state_r == BK_MATCH) begin
      hit_r  <= hit_c;
      slot_r <= slot_c;
      if (!it_r.rdy) begin
        res_em_r  <= 1'b0;
        res_cnt_r <= '0;
      end
    end
    if (state_r == BK_UPDATE) begin
      res_em_r <= open;
      if (open) begin
        if (!hit_r) res_cnt_r <= CntBits'(1);
        else res_cnt_r <= (sup_rd_r == CntMax) ? CntMax : sup_rd_r + 1'b1;
      end else begin
        res_cnt_r <= '0;
      end
    end
  end

  // Update entry payload
  always_ff @(posedge clk) begin
    if (state_r == BK_UPDATE) begin
      if (!hit_r) key_r[gs] <= it_r.key;
      if (open) begin
        last_r[gs] <= it_r.now;
        sup_r[gs]  <= '0;
      end else if (sup_rd_r != CntMax) begin
        sup_r[gs] <= sup_rd_r + 1'b1;
      end
      // Reorder ranks: touched slot becomes most recent
      for (int i = 0; i < TableEntries; i++) begin
        if (SlotBits'(i) == slot_r) begin
          rank_r[gs] <= (hit_r || full) ? SlotBits'(fill_c - 1'b1) : SlotBits'(fill_c);
        end else if (hit_r) begin
          if (FillBits'(i) < fill_c && rank_r[{it_r.tsel, SlotBits'(i)}] > old_rank)
            rank_r[{it_r.tsel, SlotBits'(i)}] <= rank_r[{it_r.tsel, SlotBits'(i)}] - 1'b1;
        end else if (full) begin
          rank_r[{it_r.tsel, SlotBits'(i)}] <= rank_r[{it_r.tsel, SlotBits'(i)}] - 1'b1;
        end
      end
    end
  end

  // Control state: emitted flags and fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hasem_r <= '0;
      for (int t = 0; t < NumTables; t++) fill_r[t] <= '0;
    end else if (state_r == BK_UPDATE) begin
      if (open) hasem_r[gs] <= 1'b1;
      if (!hit_r && !full) fill_r[it_r.tsel] <= fill_c + 1'b1;
    end
  end
endmodule

/* src/keyed_window_rate_limiter_lru_top.sv */
// Channel | Dir | Payload
// in      | in  | table_select, key_id, now_ms, audit_ready
// out     | out | emitted, window_count
// cfg     | in  | data (window length)
// Each beat passes through the back end's pop, match and update steps, then the
// output beat; a no-op beat skips the update. A two-entry queue takes input
// beats while the back end works. Reset clears fill counts and emitted flags,
// the window returns to 60000. Out stalls hold the back end; the queue then
// fills and drops in_ready.
`include "assert_macros.svh"
module keyed_window_rate_limiter_lru_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_table_select,
  input  logic [31:0] in_key_id,
  input  logic [47:0] in_now_ms,
  input  logic        in_audit_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_emitted,
  output logic [31:0] out_window_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import kwrl_pkg::*;

  logic [WinBits-1:0] window_r;
  logic               q_valid, q_pop, busy;
  item_t              q_item;

  assign cfg_ready = 1'b1;

  // Hold the window register
  always_ff @(posedge clk) begin
    if (!rst_n) window_r <= WindowReset;
    else if (cfg_valid) window_r <= cfg_data;
  end

  kwrl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_table_select, .in_key_id,
    .in_now_ms, .in_audit_ready, .q_valid, .q_pop, .q_item
  );

  kwrl_back u_back (
    .clk, .rst_n, .window(window_r), .q_valid, .q_pop, .q_item,
    .out_valid, .out_ready, .out_emitted, .out_window_count, .busy
  );

  `ASSERT_IMPL(a_pop_needs_item, !q_pop || q_valid)
  `ASSERT_IMPL(a_out_only_busy, !out_valid || busy)
  `ASSERT_IMPL(a_quiet_count, out_emitted || out_window_count == '0 || !out_valid)
  `ASSERT_NEXT(a_pop_busy, q_pop, busy)
endmodule
